// File: hdl/ptc_pkg.sv
package ptc_pkg;

  // Button lanes tracked and fixed-point fraction of the pointer position.
  localparam int NUM_BUTTONS = 5;
  localparam int FRAC_BITS   = 8;

  // Field widths.
  localparam int DELTA_W    = 8;
  localparam int BTN_W      = 5;
  localparam int TIME_W     = 32;
  localparam int COORD_W    = 12;
  localparam int SPEED_W    = 16;
  localparam int MS_W       = 16;
  localparam int POS_W      = COORD_W + FRAC_BITS;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [COORD_W-1:0] MAX_X_RST   = COORD_W'(720);
  localparam logic [COORD_W-1:0] MAX_Y_RST   = COORD_W'(576);
  localparam logic [SPEED_W-1:0] SPEED_RST   = SPEED_W'(256);
  localparam logic [MS_W-1:0]    DBL_WIN_RST = MS_W'(500);
  localparam logic [MS_W-1:0]    ACT_TO_RST  = MS_W'(3000);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_X   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_X = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_Y = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_DBL_WIN = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_TO  = CFG_IDX_W'(5);

  typedef logic [POS_W-1:0]       pos_t;
  typedef logic [NUM_BUTTONS-1:0] btn_mask_t;

  // Center of an axis: max times half of one integer step.
  function automatic pos_t center(input logic [COORD_W-1:0] max_v);
    center = POS_W'({max_v, {(FRAC_BITS - 1){1'b0}}});
  endfunction

  // The raw report orders left, middle, right; the lanes order left, right, middle.
  function automatic btn_mask_t btn_remap(input logic [BTN_W-1:0] raw);
    btn_mask_t m;
    int src;
    m = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      src = (i == 1) ? 2 : (i == 2) ? 1 : i;
      if (src < BTN_W) begin
        m[i] = raw[src];
      end
    end
    btn_remap = m;
  endfunction

endpackage

// File: hdl/pointer_tracker_click_detect_core.sv
// Channel  | Ports                                            | Direction
// ---------+--------------------------------------------------+----------
// input    | in_valid, in_stall, in_delta_x/y, in_buttons_raw,| in
//          | in_now_ms                                        |
// result   | out_valid, out_stall, out_pos_x/y, out_moved,    | out
//          | out_active, out_*_mask, out_pointer_reset        |
// config   | cfg_wr_en, cfg_index, cfg_data                   | in
//
// One transfer per clock is sustained while out_stall is low; a report moves from
// the input register to the result register, where its result is offered.
// The update is a single pass: multiply, add and clamp per axis, plus the
// per-button compares, between the input register and the result register.
// rst_n is synchronous and active low; it restores register defaults and
// centers the pointer. A stalled result holds, and the input register still
// accepts one more report before in_stall rises.
module pointer_tracker_click_detect_core
  import ptc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [DELTA_W-1:0] in_delta_x,
  input  logic signed [DELTA_W-1:0] in_delta_y,
  input  logic [BTN_W-1:0]          in_buttons_raw,
  input  logic [TIME_W-1:0]         in_now_ms,

  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [COORD_W-1:0]        out_pos_x,
  output logic [COORD_W-1:0]        out_pos_y,
  output logic                      out_moved,
  output logic                      out_active,
  output logic [BTN_W-1:0]          out_down_mask,
  output logic [BTN_W-1:0]          out_click_mask,
  output logic [BTN_W-1:0]          out_double_click_mask,
  output logic [BTN_W-1:0]          out_hold_mask,
  output logic                      out_pointer_reset,

  input  logic                      cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  // Configuration registers.
  logic [COORD_W-1:0] max_x_r, max_y_r;
  logic [SPEED_W-1:0] speed_x_r, speed_y_r;
  logic [MS_W-1:0]    dbl_win_r, act_to_r;

  // Tracking state.
  pos_t              pos_x_r, pos_y_r;
  pos_t              pos_x_nxt, pos_y_nxt;
  btn_mask_t         prev_down_r;
  logic [TIME_W-1:0] rel_time_r [NUM_BUTTONS];
  logic [TIME_W-1:0] motion_time_r;
  logic              active_r;

  // Input register.
  logic                      s1_vld_r;
  logic signed [DELTA_W-1:0] s1_dx_r, s1_dy_r;
  logic [BTN_W-1:0]          s1_btn_r;
  logic [TIME_W-1:0]         s1_now_r;

  // Result register.
  logic                      out_vld_r;
  logic [COORD_W-1:0]        pos_x_q_r, pos_y_q_r;
  logic                      moved_q_r, active_q_r, preset_q_r;
  btn_mask_t                 down_q_r, click_q_r, dbl_q_r, hold_q_r;

  // Single-pass update results.
  logic      adv;
  logic      step_en;
  logic      moved;
  logic      active_nxt;
  btn_mask_t down, click, dbl, hold;
  logic [TIME_W-1:0] since_motion;
  logic [TIME_W-1:0] since_rel [NUM_BUTTONS];

  // The result register moves whenever it is empty or its transfer completes;
  // the input register then hands its report over in the same edge.
  assign adv      = !out_vld_r || !out_stall;
  assign step_en  = s1_vld_r && adv;
  assign in_stall = s1_vld_r && !adv;

  ptc_axis u_axis_x (
    .pos     (pos_x_r),
    .delta   (s1_dx_r),
    .speed   (speed_x_r),
    .max_v   (max_x_r),
    .pos_nxt (pos_x_nxt)
  );

  ptc_axis u_axis_y (
    .pos     (pos_y_r),
    .delta   (s1_dy_r),
    .speed   (speed_y_r),
    .max_v   (max_y_r),
    .pos_nxt (pos_y_nxt)
  );

  // Activity and per-button classification. Time differences wrap modulo 2^32.
  always_comb begin
    down  = btn_remap(s1_btn_r);
    moved = (s1_dx_r != '0) || (s1_dy_r != '0);
    since_motion = s1_now_r - motion_time_r;
    if (moved) begin
      active_nxt = 1'b1;
    end else if (since_motion > TIME_W'(act_to_r)) begin
      active_nxt = 1'b0;
    end else begin
      active_nxt = active_r;
    end
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      since_rel[i] = s1_now_r - rel_time_r[i];
      hold[i]  = down[i] && prev_down_r[i];
      dbl[i]   = down[i] && !prev_down_r[i] && (since_rel[i] < TIME_W'(dbl_win_r));
      click[i] = !down[i] && prev_down_r[i];
    end
  end

  // Configuration and tracking state. The user must write only while the block is idle, so
  // that a max write recentering the pointer never meets a report update; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_x_r       <= MAX_X_RST;
      max_y_r       <= MAX_Y_RST;
      speed_x_r     <= SPEED_RST;
      speed_y_r     <= SPEED_RST;
      dbl_win_r     <= DBL_WIN_RST;
      act_to_r      <= ACT_TO_RST;
      pos_x_r       <= center(MAX_X_RST);
      pos_y_r       <= center(MAX_Y_RST);
      prev_down_r   <= '0;
      motion_time_r <= '0;
      active_r      <= 1'b0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        rel_time_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MAX_X: begin
          max_x_r <= cfg_data[COORD_W-1:0];
          pos_x_r <= center(cfg_data[COORD_W-1:0]);
          pos_y_r <= center(max_y_r);
        end
        CFG_MAX_Y: begin
          max_y_r <= cfg_data[COORD_W-1:0];
          pos_x_r <= center(max_x_r);
          pos_y_r <= center(cfg_data[COORD_W-1:0]);
        end
        CFG_SPEED_X: speed_x_r <= cfg_data[SPEED_W-1:0];
        CFG_SPEED_Y: speed_y_r <= cfg_data[SPEED_W-1:0];
        CFG_DBL_WIN: dbl_win_r <= cfg_data[MS_W-1:0];
        CFG_ACT_TO:  act_to_r  <= cfg_data[MS_W-1:0];
        default: begin
        end
      endcase
    end else if (step_en) begin
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      prev_down_r <= down;
      active_r    <= active_nxt;
      if (moved) begin
        motion_time_r <= s1_now_r;
      end
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (click[i]) begin
          rel_time_r[i] <= s1_now_r;
        end
      end
    end
  end

  // Input register: takes a report whenever it is empty or handing over.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_dx_r  <= in_delta_x;
      s1_dy_r  <= in_delta_y;
      s1_btn_r <= in_buttons_raw;
      s1_now_r <= in_now_ms;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      pos_x_q_r  <= pos_x_nxt[POS_W-1:FRAC_BITS];
      pos_y_q_r  <= pos_y_nxt[POS_W-1:FRAC_BITS];
      moved_q_r  <= moved;
      active_q_r <= active_nxt;
      down_q_r   <= down;
      click_q_r  <= click;
      dbl_q_r    <= dbl;
      hold_q_r   <= hold;
      // Set only when no button is down and none was released.
      preset_q_r <= (down == '0) && (click == '0);
    end
  end

  assign out_valid             = out_vld_r;
  assign out_pos_x             = pos_x_q_r;
  assign out_pos_y             = pos_y_q_r;
  assign out_moved             = moved_q_r;
  assign out_active            = active_q_r;
  assign out_down_mask         = BTN_W'(down_q_r);
  assign out_click_mask        = BTN_W'(click_q_r);
  assign out_double_click_mask = BTN_W'(dbl_q_r);
  assign out_hold_mask         = BTN_W'(hold_q_r);
  assign out_pointer_reset     = preset_q_r;

endmodule

// File: hdl/ptc_axis.sv
module ptc_axis
  import ptc_pkg::*;
(
  input  pos_t                      pos,
  input  logic signed [DELTA_W-1:0] delta,
  input  logic [SPEED_W-1:0]        speed,
  input  logic [COORD_W-1:0]        max_v,
  output pos_t                      pos_nxt
);

  localparam int PROD_W = DELTA_W + SPEED_W + 1;
  localparam int SH_L   = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
  localparam int SH_R   = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;
  localparam int STEP_W = PROD_W + SH_L;
  localparam int SUM_W  = ((POS_W > STEP_W) ? POS_W : STEP_W) + 2;

  logic signed [PROD_W-1:0] prod;
  logic signed [STEP_W-1:0] step;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  lim_s;
  pos_t                     lim;

  // The gain has eight fraction bits; an arithmetic right shift floors.
  always_comb begin
    prod  = PROD_W'(delta) * $signed({1'b0, speed});
    step  = (STEP_W'(prod) <<< SH_L) >>> SH_R;
    sum   = SUM_W'($signed({1'b0, pos})) + SUM_W'(step);
    lim   = POS_W'({max_v, {FRAC_BITS{1'b0}}});
    lim_s = SUM_W'($signed({1'b0, lim}));
    if (sum[SUM_W-1]) begin
      pos_nxt = '0;
    end else if (sum > lim_s) begin
      pos_nxt = lim;
    end else begin
      pos_nxt = POS_W'(sum);
    end
  end

endmodule

// File: verif/ptc_report_checker.sv
module ptc_report_checker
  import ptc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic signed [DELTA_W-1:0] in_delta_x,
  input  logic signed [DELTA_W-1:0] in_delta_y,
  input  logic [BTN_W-1:0]          in_buttons_raw,
  input  logic [TIME_W-1:0]         in_now_ms,

  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [COORD_W-1:0]        out_pos_x,
  input  logic [COORD_W-1:0]        out_pos_y,
  input  logic                      out_moved,
  input  logic                      out_active,
  input  logic [BTN_W-1:0]          out_down_mask,
  input  logic [BTN_W-1:0]          out_click_mask,
  input  logic [BTN_W-1:0]          out_double_click_mask,
  input  logic [BTN_W-1:0]          out_hold_mask,
  input  logic                      out_pointer_reset,

  input  logic                      cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,

  output int                        fail_count,
  output int                        due_count
);

  typedef struct packed {
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic               moved;
    logic               active;
    btn_mask_t          down;
    btn_mask_t          click;
    btn_mask_t          dbl;
    btn_mask_t          hold;
    logic               pointer_reset;
  } pointer_report_t;

  // Shadow copy of the registers and the tracking state.
  logic [COORD_W-1:0] lim_x, lim_y;
  logic [SPEED_W-1:0] gain_x, gain_y;
  logic [MS_W-1:0]    dbl_window, idle_timeout;
  pos_t               pos_x_fx, pos_y_fx;
  btn_mask_t          held_mask;
  logic [TIME_W-1:0]  released_at [NUM_BUTTONS];
  logic [TIME_W-1:0]  motion_stamp;
  logic               active_now;

  pointer_report_t    reports_due[$];
  int                 fails = 0;
  int                 outstanding = 0;

  assign fail_count = fails;
  assign due_count  = outstanding;

  task automatic report_mismatch(input string msg);
    fails++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  task recenter();
    pos_x_fx = pos_t'(lim_x) << (FRAC_BITS - 1);
    pos_y_fx = pos_t'(lim_y) << (FRAC_BITS - 1);
  endtask

  task reset_tracker();
    lim_x        = MAX_X_RST;
    lim_y        = MAX_Y_RST;
    gain_x       = SPEED_RST;
    gain_y       = SPEED_RST;
    dbl_window   = DBL_WIN_RST;
    idle_timeout = ACT_TO_RST;
    recenter();
    held_mask    = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) released_at[i] = '0;
    motion_stamp = '0;
    active_now   = 1'b0;
  endtask

  task apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_MAX_X: begin
        lim_x = val[COORD_W-1:0];
        recenter();
      end
      CFG_MAX_Y: begin
        lim_y = val[COORD_W-1:0];
        recenter();
      end
      CFG_SPEED_X: gain_x = val[SPEED_W-1:0];
      CFG_SPEED_Y: gain_y = val[SPEED_W-1:0];
      CFG_DBL_WIN: dbl_window = val[MS_W-1:0];
      CFG_ACT_TO:  idle_timeout = val[MS_W-1:0];
      default: ;
    endcase
  endtask

  // Motion is scaled by the 8.8 gain, moved to FRAC_BITS fraction bits with
  // rounding toward minus infinity, and clamped to 0..max with zero fraction.
  function automatic pos_t move_axis(input pos_t pos, input logic signed [DELTA_W-1:0] d,
                                     input logic [SPEED_W-1:0] gain,
                                     input logic [COORD_W-1:0] lim);
    longint scaled;
    longint p;
    longint p_max;
    scaled = longint'(d) * longint'(gain) * (longint'(1) << FRAC_BITS);
    p      = longint'(pos) + (scaled >>> 8);
    p_max  = longint'(lim) << FRAC_BITS;
    if (p < 0) p = 0;
    if (p > p_max) p = p_max;
    return pos_t'(p);
  endfunction

  task track_report(input logic signed [DELTA_W-1:0] dx, input logic signed [DELTA_W-1:0] dy,
                    input logic [BTN_W-1:0] raw, input logic [TIME_W-1:0] now,
                    output pointer_report_t r);
    btn_mask_t         pressed;
    int                src;
    logic [TIME_W-1:0] elapsed;
    r        = '0;
    r.moved  = (dx != 0) || (dy != 0);
    pos_x_fx = move_axis(pos_x_fx, dx, gain_x, lim_x);
    pos_y_fx = move_axis(pos_y_fx, dy, gain_y, lim_y);

    elapsed = now - motion_stamp;
    if (r.moved) begin
      active_now   = 1'b1;
      motion_stamp = now;
    end else if (elapsed > TIME_W'(idle_timeout)) begin
      active_now = 1'b0;
    end

    // Lanes are left, right, middle while the report carries left, middle, right.
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      src = (i == 1) ? 2 : (i == 2) ? 1 : i;
      pressed[i] = (src < BTN_W) ? raw[src] : 1'b0;
    end

    for (int i = 0; i < NUM_BUTTONS; i++) begin
      elapsed = now - released_at[i];
      if (pressed[i]) begin
        if (held_mask[i]) begin
          r.hold[i] = 1'b1;
        end else if (elapsed < TIME_W'(dbl_window)) begin
          r.dbl[i] = 1'b1;
        end
      end else if (held_mask[i]) begin
        r.click[i]     = 1'b1;
        released_at[i] = now;
      end
    end
    held_mask       = pressed;

    r.down          = pressed;
    r.pos_x         = pos_x_fx[FRAC_BITS +: COORD_W];
    r.pos_y         = pos_y_fx[FRAC_BITS +: COORD_W];
    r.active        = active_now;
    r.pointer_reset = (pressed == '0) && (r.click == '0);
  endtask

  always @(posedge clk) begin
    pointer_report_t want;
    pointer_report_t fresh;
    if (!rst_n) begin
      reset_tracker();
      reports_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          report_mismatch("result transfer with no report outstanding");
        end else begin
          want = reports_due.pop_front();
          if (out_pos_x !== want.pos_x)
            report_mismatch($sformatf("pos_x got %0d expected %0d", out_pos_x, want.pos_x));
          if (out_pos_y !== want.pos_y)
            report_mismatch($sformatf("pos_y got %0d expected %0d", out_pos_y, want.pos_y));
          if (out_moved !== want.moved)
            report_mismatch($sformatf("moved got %b expected %b", out_moved, want.moved));
          if (out_active !== want.active)
            report_mismatch($sformatf("active got %b expected %b", out_active, want.active));
          if (out_down_mask !== want.down)
            report_mismatch($sformatf("down_mask got %b expected %b",
                                      out_down_mask, want.down));
          if (out_click_mask !== want.click)
            report_mismatch($sformatf("click_mask got %b expected %b",
                                      out_click_mask, want.click));
          if (out_double_click_mask !== want.dbl)
            report_mismatch($sformatf("double_click_mask got %b expected %b",
                                      out_double_click_mask, want.dbl));
          if (out_hold_mask !== want.hold)
            report_mismatch($sformatf("hold_mask got %b expected %b",
                                      out_hold_mask, want.hold));
          if (out_pointer_reset !== want.pointer_reset)
            report_mismatch($sformatf("pointer_reset got %b expected %b",
                                      out_pointer_reset, want.pointer_reset));
        end
      end
      if (cfg_wr_en) begin
        apply_write(cfg_index, cfg_data);
      end
      if (in_valid && !in_stall) begin
        track_report(in_delta_x, in_delta_y, in_buttons_raw, in_now_ms, fresh);
        reports_due.push_back(fresh);
      end
    end
    outstanding = reports_due.size();
  end

endmodule

// File: verif/tb.sv
module tb;
  import ptc_pkg::*;

  // Indexes past the last register; writes to them must leave the block untouched.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(7);

  // Generous bound: about 1250 reports, plus gaps and stalls.
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_REPORTS = 245;

  logic                      clk;
  logic                      rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [DELTA_W-1:0] in_delta_x = '0;
  logic signed [DELTA_W-1:0] in_delta_y = '0;
  logic [BTN_W-1:0]          in_buttons_raw = '0;
  logic [TIME_W-1:0]         in_now_ms = '0;

  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [COORD_W-1:0]        out_pos_x;
  logic [COORD_W-1:0]        out_pos_y;
  logic                      out_moved;
  logic                      out_active;
  logic [BTN_W-1:0]          out_down_mask;
  logic [BTN_W-1:0]          out_click_mask;
  logic [BTN_W-1:0]          out_double_click_mask;
  logic [BTN_W-1:0]          out_hold_mask;
  logic                      out_pointer_reset;

  logic                      cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  int                        fail_count;
  int                        due_count;
  int                        cycles = 0;

  // When cleared, the matching side never pauses; this gives a stretch of
  // back-to-back transfers in both directions.
  bit                        sender_pauses = 1'b1;
  bit                        receiver_pauses = 1'b1;

  // Stimulus-side view of time, button state and the timing registers, used
  // only to aim reports at the interesting boundaries.
  logic [TIME_W-1:0]         clock_ms = '0;
  logic [BTN_W-1:0]          buttons_now = '0;
  logic [MS_W-1:0]           window_ms = DBL_WIN_RST;
  logic [MS_W-1:0]           timeout_ms = ACT_TO_RST;

  pointer_tracker_click_detect_core dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_delta_x            (in_delta_x),
    .in_delta_y            (in_delta_y),
    .in_buttons_raw        (in_buttons_raw),
    .in_now_ms             (in_now_ms),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_pos_x             (out_pos_x),
    .out_pos_y             (out_pos_y),
    .out_moved             (out_moved),
    .out_active            (out_active),
    .out_down_mask         (out_down_mask),
    .out_click_mask        (out_click_mask),
    .out_double_click_mask (out_double_click_mask),
    .out_hold_mask         (out_hold_mask),
    .out_pointer_reset     (out_pointer_reset),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  ptc_report_checker report_check (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_delta_x            (in_delta_x),
    .in_delta_y            (in_delta_y),
    .in_buttons_raw        (in_buttons_raw),
    .in_now_ms             (in_now_ms),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_pos_x             (out_pos_x),
    .out_pos_y             (out_pos_y),
    .out_moved             (out_moved),
    .out_active            (out_active),
    .out_down_mask         (out_down_mask),
    .out_click_mask        (out_click_mask),
    .out_double_click_mask (out_double_click_mask),
    .out_hold_mask         (out_hold_mask),
    .out_pointer_reset     (out_pointer_reset),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .fail_count            (fail_count),
    .due_count             (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls with a chance of about nine in a hundred. The stall changes
  // only at the falling edge, so the block sees a settled value at the rising edge.
  always @(negedge clk) begin
    out_stall <= receiver_pauses && ($urandom_range(99) < 9);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d reports outstanding", cycles, due_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Presents one report and returns at the falling edge after its transfer.
  // Valid stays high on return, so consecutive reports go back to back unless
  // the next call decides to pause first. Called at a falling edge.
  task automatic send_report(input logic signed [DELTA_W-1:0] dx,
                             input logic signed [DELTA_W-1:0] dy,
                             input logic [BTN_W-1:0] raw, input logic [TIME_W-1:0] now);
    while (sender_pauses && ($urandom_range(99) < 9)) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_delta_x     = dx;
    in_delta_y     = dy;
    in_buttons_raw = raw;
    in_now_ms      = now;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Lowers valid and waits until every report sent so far has come back,
  // so that a register write lands on an idle block.
  task automatic drain();
    in_valid = 1'b0;
    while (due_count != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    if (idx == CFG_DBL_WIN) window_ms = val;
    if (idx == CFG_ACT_TO) timeout_ms = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Each phase runs under its own register setting. The first two phases sit on
  // the extremes of every register; the third rewrites the reset geometry through
  // data with stray upper bits and pokes the spare indexes; the last two are random.
  task automatic program_phase(input int phase);
    case (phase)
      1: begin
        write_reg(CFG_MAX_X, 16'd4095);
        write_reg(CFG_MAX_Y, 16'd0);
        write_reg(CFG_SPEED_X, 16'hFFFF);
        write_reg(CFG_SPEED_Y, 16'd0);
        write_reg(CFG_DBL_WIN, 16'd0);
        write_reg(CFG_ACT_TO, 16'd0);
      end
      2: begin
        write_reg(CFG_MAX_X, 16'd0);
        write_reg(CFG_MAX_Y, 16'd4095);
        write_reg(CFG_SPEED_X, 16'd0);
        write_reg(CFG_SPEED_Y, 16'hFFFF);
        write_reg(CFG_DBL_WIN, 16'hFFFF);
        write_reg(CFG_ACT_TO, 16'hFFFF);
      end
      3: begin
        write_reg(CFG_MAX_X, 16'hF2D0);
        write_reg(CFG_MAX_Y, 16'hA240);
        write_reg(CFG_SPEED_X, 16'd128);
        write_reg(CFG_SPEED_Y, 16'd384);
        write_reg(CFG_DBL_WIN, 16'd300);
        write_reg(CFG_ACT_TO, 16'd1000);
        write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
        write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
      end
      4: begin
        write_reg(CFG_MAX_X, CFG_DATA_W'($urandom_range(0, 4095)));
        write_reg(CFG_MAX_Y, CFG_DATA_W'($urandom_range(0, 4095)));
        write_reg(CFG_SPEED_X, CFG_DATA_W'($urandom_range(0, 1023)));
        write_reg(CFG_SPEED_Y, CFG_DATA_W'($urandom_range(0, 1023)));
        write_reg(CFG_DBL_WIN, CFG_DATA_W'($urandom_range(0, 2000)));
        write_reg(CFG_ACT_TO, CFG_DATA_W'($urandom_range(0, 5000)));
      end
      default: begin
        write_reg(CFG_MAX_X, CFG_DATA_W'($urandom));
        write_reg(CFG_MAX_Y, CFG_DATA_W'($urandom));
        write_reg(CFG_SPEED_X, CFG_DATA_W'($urandom));
        write_reg(CFG_SPEED_Y, CFG_DATA_W'($urandom));
        write_reg(CFG_DBL_WIN, CFG_DATA_W'($urandom));
        write_reg(CFG_ACT_TO, CFG_DATA_W'($urandom));
      end
    endcase
  endtask

  // A random report. Time mostly creeps forward in steps around the click window,
  // now and then lands right on the window or timeout edge, jumps past the longest
  // timeout, or leaps to any value. Buttons mostly evolve from the previous report
  // so that press, hold, release and re-press sequences occur often.
  task automatic send_random_report();
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    int                        pick;

    pick = $urandom_range(99);
    if (pick < 50) clock_ms += $urandom_range(0, 300);
    else if (pick < 75) clock_ms += $urandom_range(300, 800);
    else if (pick < 82) clock_ms += TIME_W'(window_ms) + $urandom_range(0, 2) - 1;
    else if (pick < 89) clock_ms += TIME_W'(timeout_ms) + $urandom_range(0, 2) - 1;
    else if (pick < 96) clock_ms += $urandom_range(0, 70000);
    else clock_ms = $urandom;

    pick = $urandom_range(99);
    if (pick < 35) begin
      dx = '0;
      dy = '0;
    end else if (pick < 75) begin
      dx = DELTA_W'(int'($urandom_range(0, 16)) - 8);
      dy = DELTA_W'(int'($urandom_range(0, 16)) - 8);
    end else if (pick < 90) begin
      dx = DELTA_W'($urandom);
      dy = DELTA_W'($urandom);
    end else begin
      dx = $urandom_range(1) ? 8'sd127 : -8'sd128;
      dy = $urandom_range(1) ? 8'sd127 : -8'sd128;
    end

    pick = $urandom_range(99);
    if (pick < 8) begin
      buttons_now = BTN_W'($urandom);
    end else if (pick < 18) begin
      buttons_now = '0;
    end else begin
      for (int b = 0; b < BTN_W; b++) begin
        if ($urandom_range(4) == 0) buttons_now[b] = ~buttons_now[b];
      end
    end

    send_report(dx, dy, buttons_now, clock_ms);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed reports under the reset setting (window 500, timeout 3000).
    // A first press right after reset counts as a double click, because the
    // release times start at zero.
    send_report(0, 0, 5'h00, 32'd0);
    send_report(127, -128, 5'h1F, 32'd100);
    send_report(127, 127, 5'h1F, 32'd200);
    // The third rightward step drives x into the upper clamp.
    send_report(127, 0, 5'h00, 32'd300);
    // 499 ms after the release: still a double click. 500 ms: no longer.
    send_report(-128, 0, 5'h1F, 32'd799);
    send_report(0, 0, 5'h00, 32'd900);
    send_report(0, 0, 5'h1F, 32'd1400);
    send_report(0, 0, 5'h00, 32'd1500);
    // Middle and right swap places between the report and the lane masks.
    send_report(0, 0, 5'b00001, 32'd2000);
    send_report(0, 0, 5'b00110, 32'd2100);
    // The activity flag survives a gap equal to the timeout and drops one later.
    send_report(0, 0, 5'h00, 32'd3799);
    send_report(0, 0, 5'h00, 32'd3800);
    // Steps to the left and down until both axes sit on the lower clamp.
    for (int k = 0; k < 5; k++) begin
      send_report(-128, -128, 5'h00, 32'd3900 + 32'(k) * 32'd100);
    end
    // Time wraps: a release just before the wrap and a press just after it
    // are 144 ms apart, and the activity gap is measured across the wrap too.
    send_report(1, 0, 5'b01000, 32'hFFFF_FF00);
    send_report(0, 0, 5'h00, 32'hFFFF_FF80);
    send_report(0, 0, 5'b11000, 32'h0000_0010);
    send_report(0, 0, 5'h00, 32'h0000_2000);
    send_report(-1, 1, 5'h15, 32'h0000_2001);
    buttons_now = 5'h15;
    clock_ms    = 32'h0000_2001;

    for (int phase = 1; phase <= 5; phase++) begin
      drain();
      program_phase(phase);
      // Phase three runs with no pauses on either side.
      sender_pauses   = (phase != 3);
      receiver_pauses = (phase != 3);
      for (int n = 0; n < PHASE_REPORTS; n++) begin
        send_random_report();
      end
    end

    drain();
    // Keep the clock running to catch any stray result after the last one expected.
    repeat (4) @(posedge clk);
    if (fail_count == 0 && due_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/ptc_pkg.sv
hdl/ptc_axis.sv
hdl/pointer_tracker_click_detect_core.sv
verif/ptc_report_checker.sv
verif/tb.sv
